// ===== rtl/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

    // Line length limit and line position width
    localparam int MAX_LINE = 1024;
    localparam int POS_W    = $clog2(MAX_LINE + 1);

    // Command table
    localparam int NUM_CMDS = 11;
    localparam int CMD_CHARS = 11;
    localparam logic [3:0] CMD_NONE = 4'd11;
    localparam logic [NUM_CMDS-1:0] ALL_MASK = '1;

    // Names padded with spaces to the longest name; padding is never compared
    localparam logic [8*CMD_CHARS-1:0] CMD_TEXT [NUM_CMDS] = '{
        "SEND       ", "SUBSCRIBE  ", "CONNECT    ", "STOMP      ",
        "ACK        ", "BEGIN      ", "COMMIT     ", "ABORT      ",
        "NACK       ", "UNSUBSCRIBE", "DISCONNECT "
    };
    localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{
        4'd4, 4'd9, 4'd7, 4'd5, 4'd3, 4'd5, 4'd6, 4'd5, 4'd4, 4'd11, 4'd10
    };

    // Framing phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NAME = 2'd1;
    localparam logic [1:0] PH_HDR  = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    // Result tags
    localparam logic [3:0] K_SKIP      = 4'd0;
    localparam logic [3:0] K_NAME      = 4'd1;
    localparam logic [3:0] K_NAME_OK   = 4'd2;
    localparam logic [3:0] K_NAME_BAD  = 4'd3;
    localparam logic [3:0] K_HDR       = 4'd4;
    localparam logic [3:0] K_HDR_END   = 4'd5;
    localparam logic [3:0] K_HDRS_DONE = 4'd6;
    localparam logic [3:0] K_BODY      = 4'd7;
    localparam logic [3:0] K_FRAME_END = 4'd8;
    localparam logic [3:0] K_OVERFLOW  = 4'd9;

    // Special bytes
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef struct packed {
        logic [1:0]          phase;
        logic [POS_W-1:0]    line_pos;
        logic [NUM_CMDS-1:0] match_mask;
        logic [3:0]          cmd;
    } t_state;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [3:0] kind;
        logic [3:0] command_code;
    } t_result;

    // Character k of command i
    function automatic logic [7:0] cmd_char(input int i, input logic [3:0] k);
        logic [8*CMD_CHARS-1:0] t;
        t = CMD_TEXT[i] << {k, 3'b000};
        return t[8*CMD_CHARS-1 -: 8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sfd_ifs.sv =====
`default_nettype none

// Received byte channel
interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// Tagged byte channel
interface sfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [3:0] kind;
    logic [3:0] command_code;

    modport source (output valid, output byte_out, output kind, output command_code,
                    input ready);
    modport sink   (input valid, input byte_out, input kind, input command_code,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/sfd_step.sv =====
`default_nettype none

// Tags one byte against the frame structure and computes the next framing state
module sfd_step (
    input  wire logic [7:0]      i_byte,
    input  wire sfd_pkg::t_state i_state,
    output sfd_pkg::t_state      o_next,
    output sfd_pkg::t_result     o_result
);
    import sfd_pkg::*;

    logic                is_lf, is_cr, is_nul, is_sep;
    logic                at_start, at_limit;
    logic [NUM_CMDS-1:0] mask_cont;
    logic [NUM_CMDS-1:0] mask_first;
    logic [3:0]          pick;
    logic [3:0]          kind;
    logic [3:0]          code;

    assign is_lf    = (i_byte == CH_LF);
    assign is_cr    = (i_byte == CH_CR);
    assign is_nul   = (i_byte == CH_NUL);
    assign is_sep   = is_lf || is_cr || is_nul;
    assign at_start = (i_state.line_pos == '0);
    assign at_limit = (i_state.line_pos >= POS_W'(MAX_LINE));

    // Per-command prefix compare, one lane per command
    always_comb begin
        for (int i = 0; i < NUM_CMDS; i++) begin
            mask_cont[i] = i_state.match_mask[i];
            if ((i_state.line_pos < POS_W'(CMD_LEN[i])) &&
                (cmd_char(i, i_state.line_pos[3:0]) != i_byte)) begin
                mask_cont[i] = 1'b0;
            end
            mask_first[i] = (cmd_char(i, 4'd0) == i_byte);
        end
    end

    // First command in table order that is fully matched
    always_comb begin
        pick = CMD_NONE;
        for (int i = NUM_CMDS - 1; i >= 0; i--) begin
            if (i_state.match_mask[i] && (i_state.line_pos >= POS_W'(CMD_LEN[i]))) begin
                pick = 4'(i);
            end
        end
    end

    // Framing decisions
    always_comb begin
        o_next = i_state;
        kind   = K_SKIP;
        code   = CMD_NONE;
        unique case (i_state.phase)
            PH_IDLE: begin
                if (!is_sep) begin
                    // first byte of a command line
                    o_next.phase      = PH_NAME;
                    o_next.line_pos   = POS_W'(1);
                    o_next.match_mask = mask_first;
                    kind              = K_NAME;
                end
            end
            PH_NAME: begin
                if ((at_start && is_sep) || (!at_start && (is_lf || is_nul))) begin
                    if (!at_start && (pick != CMD_NONE)) begin
                        kind         = K_NAME_OK;
                        code         = pick;
                        o_next.cmd   = pick;
                        o_next.phase = PH_HDR;
                    end else begin
                        kind         = K_NAME_BAD;
                        o_next.cmd   = CMD_NONE;
                        o_next.phase = PH_NAME;
                    end
                    o_next.line_pos   = '0;
                    o_next.match_mask = ALL_MASK;
                end else if (at_limit) begin
                    kind = K_OVERFLOW;
                end else begin
                    o_next.match_mask = mask_cont;
                    o_next.line_pos   = i_state.line_pos + POS_W'(1);
                    kind              = K_NAME;
                end
            end
            PH_HDR: begin
                code = i_state.cmd;
                if (at_start && (is_lf || is_cr)) begin
                    kind         = K_HDRS_DONE;
                    o_next.phase = PH_BODY;
                end else if (at_start && is_nul) begin
                    // empty header line ended by NUL is ignored
                    kind = K_SKIP;
                    code = CMD_NONE;
                end else if (is_lf || is_nul) begin
                    kind            = K_HDR_END;
                    o_next.line_pos = '0;
                end else if (at_limit) begin
                    kind = K_OVERFLOW;
                end else begin
                    o_next.line_pos = i_state.line_pos + POS_W'(1);
                    kind            = K_HDR;
                end
            end
            PH_BODY: begin
                code = i_state.cmd;
                if (is_nul) begin
                    kind              = K_FRAME_END;
                    o_next.phase      = PH_IDLE;
                    o_next.line_pos   = '0;
                    o_next.match_mask = ALL_MASK;
                    o_next.cmd        = CMD_NONE;
                end else begin
                    kind = K_BODY;
                end
            end
            default: begin
                o_next = i_state;
            end
        endcase
    end

    assign o_result.byte_out     = i_byte;
    assign o_result.kind         = kind;
    assign o_result.command_code = code;

endmodule

`default_nettype wire

// ===== rtl/stomp_frame_deframer.sv =====
`default_nettype none

// Channel   Dir  Payload                              Handshake
// i_in      in   byte_in[7:0]                         valid/ready
// o_out     out  byte_out[7:0] kind[3:0] cmd[3:0]     valid/ready
//
// One byte per cycle sustained while the output is ready; each byte passes
// from acceptance to result through the input register, then the result register.
// The framing state (phase, line position, match mask, command) is updated
// as a byte moves from the input register into the result register.
// Reset is synchronous, active low, and returns the framer to idle.
// Output back-pressure stalls both stages; input ready is high when the
// input register is empty or moving forward this cycle.
module stomp_frame_deframer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sfd_in_if.sink    i_in,
    sfd_out_if.source o_out
);
    import sfd_pkg::*;

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_state     r_state;

    t_state     n_state;
    t_result    n_out;
    logic       out_free;
    logic       s1_move;

    // Pipeline flow control
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_move    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;

    sfd_step u_step (
        .i_byte   (r_s1_byte),
        .i_state  (r_state),
        .o_next   (n_state),
        .o_result (n_out)
    );

    // Control and framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_state.phase      <= PH_IDLE;
            r_state.line_pos   <= '0;
            r_state.match_mask <= ALL_MASK;
            r_state.cmd        <= CMD_NONE;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_move) begin
                r_state <= n_state;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_byte <= i_in.byte_in;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.byte_out     = r_out.byte_out;
    assign o_out.kind         = r_out.kind;
    assign o_out.command_code = r_out.command_code;

    // A line never keeps more bytes than the limit
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.line_pos <= POS_W'(MAX_LINE))
        else $error("line position beyond limit");

    // Headers and body always belong to a matched command
    a_cmd_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_HDR || r_state.phase == PH_BODY) |-> r_state.cmd != CMD_NONE)
        else $error("header or body phase without a command");

    // An accepted command line reports its command
    a_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == K_NAME_OK) |-> r_out.command_code != CMD_NONE)
        else $error("command accepted without a code");

    // Name bytes and rejected lines carry no command
    a_name_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == K_NAME || r_out.kind == K_NAME_BAD))
        |-> r_out.command_code == CMD_NONE)
        else $error("command code on a name byte");

    // A frame end returns the framer to idle
    a_frame_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && n_out.kind == K_FRAME_END) |=> r_state.phase == PH_IDLE)
        else $error("frame end without return to idle");

endmodule

`default_nettype wire
